>>> rtl/core/hrl_pkg.sv
// ----------------------------------------------------------------------------
// hrl_pkg
// Shared constants, codes and controller/datapath types of the hex record
// loader.
// ----------------------------------------------------------------------------
package hrl_pkg;

   // record buffer size in bytes, range 1 to 255
   localparam int MAX_RECORD_BYTES = 32;

   // field widths
   localparam int LEN_W = 8;
   localparam int CMP_W = LEN_W + 1;
   localparam int CNT_W = $clog2(MAX_RECORD_BYTES + 6);
   localparam int IDX_W = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;

   // bytes around the data field: length, two address bytes, type, checksum
   localparam int FRAME_BYTES = 5;
   localparam int HEADER_BYTES = 4;

   // characters and record types
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] TYPE_DATA = 8'h00;
   localparam logic [7:0] TYPE_END = 8'h01;

   // result kinds
   typedef enum logic [2:0] {
      KIND_DATA        = 3'd0,
      KIND_DONE        = 3'd1,
      KIND_CSUM        = 3'd2,
      KIND_MALFORMED   = 3'd3,
      KIND_UNSUPPORTED = 3'd4,
      KIND_NO_END      = 3'd5
   } kind_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RECORD,
      ST_READ,
      ST_WRITE,
      ST_HALT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic     start_record;
      logic     take_nibble;
      logic     take_byte;
      logic     emit_start;
      logic     emit_read;
      logic     emit_next;
      logic     result_load;
      kind_type result_kind;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_end;
      logic is_space;
      logic is_colon;
      logic is_hex;
      logic half_pending;
      logic byte_error;
      logic rec_malformed;
      logic sum_nonzero;
      logic type_end;
      logic type_data;
      logic length_zero;
      logic emit_last;
   } status_type;

endpackage

>>> rtl/core/hrl_req_if.sv
// ----------------------------------------------------------------------------
// hrl_req_if
// Request channel: one text character or an end of text mark.
// ----------------------------------------------------------------------------
interface hrl_req_if;

   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       text_end;

   modport source (output valid, output character, output text_end, input ready);
   modport sink (input valid, input character, input text_end, output ready);

endinterface

>>> rtl/core/hrl_rsp_if.sv
// ----------------------------------------------------------------------------
// hrl_rsp_if
// Result channel: data writes, completion and error reports.
// ----------------------------------------------------------------------------
interface hrl_rsp_if;

   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] address;
   logic [7:0]  data_byte;
   logic        last;

   modport source (output valid, output kind, output address, output data_byte,
                   output last, input ready);
   modport sink (input valid, input kind, input address, input data_byte,
                 input last, output ready);

endinterface

>>> rtl/core/hrl_ram.sv
// ----------------------------------------------------------------------------
// hrl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/hrl_datapath.sv
// ----------------------------------------------------------------------------
// hrl_datapath
// Character decode, record field registers, data buffer and result register.
// ----------------------------------------------------------------------------
module hrl_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         character,
   input  logic               text_end,
   input  hrl_pkg::cmd_type    cmd,
   output hrl_pkg::status_type sts,
   output logic [2:0]         rsp_kind,
   output logic [15:0]        rsp_address,
   output logic [7:0]         rsp_data_byte,
   output logic               rsp_last
);

   logic                      half_ff, half_in;
   logic [3:0]                nibble_ff, nibble_in;
   logic [hrl_pkg::CNT_W-1:0] count_ff, count_in;
   logic [7:0]                sum_ff, sum_in;
   logic [hrl_pkg::LEN_W-1:0] length_ff, length_in;
   logic [15:0]               address_ff, address_in;
   logic [7:0]                type_ff, type_in;
   logic [hrl_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [2:0]                kind_ff, kind_in;
   logic [15:0]               out_address_ff, out_address_in;
   logic [7:0]                out_data_ff, out_data_in;
   logic                      last_ff, last_in;

   logic [3:0]                hex_value;
   logic                      hex_ok;
   logic [7:0]                byte_value;
   logic [hrl_pkg::CMP_W-1:0] count_wide;
   logic [hrl_pkg::CMP_W-1:0] frame_len;
   logic [hrl_pkg::CNT_W-1:0] data_pos;
   logic                      data_wr;
   logic [7:0]                ram_rd_data;

   // hex digit decode
   always_comb begin
      hex_value = 4'd0;
      hex_ok = 1'b0;
      if (character >= 8'h30 && character <= 8'h39) begin
         hex_value = character[3:0];
         hex_ok = 1'b1;
      end else if ((character >= 8'h41 && character <= 8'h46) ||
                   (character >= 8'h61 && character <= 8'h66)) begin
         hex_value = character[3:0] + 4'd9;
         hex_ok = 1'b1;
      end
   end

   assign byte_value = {nibble_ff, hex_value};
   assign count_wide = hrl_pkg::CMP_W'(count_ff);
   assign frame_len = hrl_pkg::CMP_W'(length_ff) + hrl_pkg::CMP_W'(hrl_pkg::FRAME_BYTES);
   assign data_pos = count_ff - hrl_pkg::CNT_W'(hrl_pkg::HEADER_BYTES);
   assign data_wr = cmd.take_byte && (count_ff >= hrl_pkg::CNT_W'(hrl_pkg::HEADER_BYTES)) &&
                    (hrl_pkg::CMP_W'(data_pos) < hrl_pkg::CMP_W'(length_ff));

   // status toward the controller
   always_comb begin
      sts.is_end = text_end;
      sts.is_space = (character == hrl_pkg::CHAR_SPACE) ||
                     (character >= hrl_pkg::CHAR_TAB && character <= hrl_pkg::CHAR_CR);
      sts.is_colon = (character == hrl_pkg::CHAR_COLON);
      sts.is_hex = hex_ok;
      sts.half_pending = half_ff;
      sts.byte_error = (count_ff == '0) ?
                       (byte_value > 8'(hrl_pkg::MAX_RECORD_BYTES)) :
                       (count_wide >= frame_len);
      sts.rec_malformed = half_ff || (count_ff == '0) || (count_wide != frame_len);
      sts.sum_nonzero = (sum_ff != 8'd0);
      sts.type_end = (type_ff == hrl_pkg::TYPE_END);
      sts.type_data = (type_ff == hrl_pkg::TYPE_DATA);
      sts.length_zero = (length_ff == '0);
      sts.emit_last = (hrl_pkg::CMP_W'(idx_ff) + hrl_pkg::CMP_W'(1)) ==
                      hrl_pkg::CMP_W'(length_ff);
   end

   // record field updates
   always_comb begin
      half_in = half_ff;
      nibble_in = nibble_ff;
      count_in = count_ff;
      sum_in = sum_ff;
      length_in = length_ff;
      address_in = address_ff;
      type_in = type_ff;
      idx_in = idx_ff;
      if (cmd.start_record) begin
         half_in = 1'b0;
         nibble_in = 4'd0;
         count_in = '0;
         sum_in = 8'd0;
         length_in = '0;
         address_in = 16'd0;
         type_in = 8'd0;
      end
      if (cmd.take_nibble) begin
         nibble_in = hex_value;
         half_in = 1'b1;
      end
      if (cmd.take_byte) begin
         half_in = 1'b0;
         sum_in = sum_ff + byte_value;
         count_in = count_ff + hrl_pkg::CNT_W'(1);
         if (count_ff == hrl_pkg::CNT_W'(0)) begin
            length_in = byte_value;
         end else if (count_ff == hrl_pkg::CNT_W'(1)) begin
            address_in = {byte_value, address_ff[7:0]};
         end else if (count_ff == hrl_pkg::CNT_W'(2)) begin
            address_in = {address_ff[15:8], byte_value};
         end else if (count_ff == hrl_pkg::CNT_W'(3)) begin
            type_in = byte_value;
         end
      end
      if (cmd.emit_start) begin
         idx_in = '0;
      end else if (cmd.emit_next) begin
         idx_in = idx_ff + hrl_pkg::IDX_W'(1);
      end
   end

   // result payload
   always_comb begin
      kind_in = kind_ff;
      out_address_in = out_address_ff;
      out_data_in = out_data_ff;
      last_in = last_ff;
      if (cmd.result_load) begin
         kind_in = cmd.result_kind;
         if (cmd.result_kind == hrl_pkg::KIND_DATA) begin
            out_address_in = address_ff + 16'(idx_ff);
            out_data_in = ram_rd_data;
            last_in = sts.emit_last;
         end else begin
            out_address_in = 16'd0;
            out_data_in = 8'd0;
            last_in = 1'b1;
         end
      end
   end

   // control-like counters get reset
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= 1'b0;
         count_ff <= '0;
         sum_ff <= 8'd0;
      end else begin
         half_ff <= half_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      nibble_ff <= nibble_in;
      length_ff <= length_in;
      address_ff <= address_in;
      type_ff <= type_in;
      idx_ff <= idx_in;
      kind_ff <= kind_in;
      out_address_ff <= out_address_in;
      out_data_ff <= out_data_in;
      last_ff <= last_in;
   end

   // record data buffer
   hrl_ram #(
      .WIDTH (8),
      .DEPTH (hrl_pkg::MAX_RECORD_BYTES)
   ) data_ram (
      .clock   (clock),
      .wr_en   (data_wr),
      .wr_addr (data_pos[hrl_pkg::IDX_W-1:0]),
      .wr_data (byte_value),
      .rd_en   (cmd.emit_read),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_kind = kind_ff;
   assign rsp_address = out_address_ff;
   assign rsp_data_byte = out_data_ff;
   assign rsp_last = last_ff;

endmodule

>>> rtl/core/hrl_ctrl.sv
// ----------------------------------------------------------------------------
// hrl_ctrl
// Record parser state machine and result valid register.
// ----------------------------------------------------------------------------
module hrl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  hrl_pkg::status_type sts,
   output hrl_pkg::cmd_type    cmd
);

   hrl_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;
   logic               req_fire;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == hrl_pkg::ST_HALT) ||
                      (((state_ff == hrl_pkg::ST_IDLE) || (state_ff == hrl_pkg::ST_RECORD)) &&
                       out_free);
   assign req_fire = req_valid && req_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         hrl_pkg::ST_IDLE: begin
            if (req_fire) begin
               priority if (sts.is_end) begin
                  cmd.result_load = 1'b1;
                  cmd.result_kind = hrl_pkg::KIND_NO_END;
                  state_in = hrl_pkg::ST_HALT;
               end else if (sts.is_space) begin
                  state_in = hrl_pkg::ST_IDLE;
               end else if (sts.is_colon) begin
                  cmd.start_record = 1'b1;
                  state_in = hrl_pkg::ST_RECORD;
               end else begin
                  cmd.result_load = 1'b1;
                  cmd.result_kind = hrl_pkg::KIND_MALFORMED;
                  state_in = hrl_pkg::ST_HALT;
               end
            end
         end
         hrl_pkg::ST_RECORD: begin
            if (req_fire) begin
               if (sts.is_end || sts.is_space) begin
                  // record end checks
                  priority if (sts.rec_malformed) begin
                     cmd.result_load = 1'b1;
                     cmd.result_kind = hrl_pkg::KIND_MALFORMED;
                     state_in = hrl_pkg::ST_HALT;
                  end else if (sts.sum_nonzero) begin
                     cmd.result_load = 1'b1;
                     cmd.result_kind = hrl_pkg::KIND_CSUM;
                     state_in = hrl_pkg::ST_HALT;
                  end else if (sts.type_end) begin
                     cmd.result_load = 1'b1;
                     cmd.result_kind = hrl_pkg::KIND_DONE;
                     state_in = hrl_pkg::ST_HALT;
                  end else if (!sts.type_data) begin
                     cmd.result_load = 1'b1;
                     cmd.result_kind = hrl_pkg::KIND_UNSUPPORTED;
                     state_in = hrl_pkg::ST_HALT;
                  end else if (sts.is_end) begin
                     cmd.result_load = 1'b1;
                     cmd.result_kind = hrl_pkg::KIND_NO_END;
                     state_in = hrl_pkg::ST_HALT;
                  end else if (sts.length_zero) begin
                     state_in = hrl_pkg::ST_IDLE;
                  end else begin
                     cmd.emit_start = 1'b1;
                     state_in = hrl_pkg::ST_READ;
                  end
               end else if (!sts.is_hex) begin
                  cmd.result_load = 1'b1;
                  cmd.result_kind = hrl_pkg::KIND_MALFORMED;
                  state_in = hrl_pkg::ST_HALT;
               end else if (!sts.half_pending) begin
                  cmd.take_nibble = 1'b1;
               end else if (sts.byte_error) begin
                  cmd.result_load = 1'b1;
                  cmd.result_kind = hrl_pkg::KIND_MALFORMED;
                  state_in = hrl_pkg::ST_HALT;
               end else begin
                  cmd.take_byte = 1'b1;
               end
            end
         end
         hrl_pkg::ST_READ: begin
            // fetch the next buffered byte
            cmd.emit_read = 1'b1;
            state_in = hrl_pkg::ST_WRITE;
         end
         hrl_pkg::ST_WRITE: begin
            if (out_free) begin
               cmd.result_load = 1'b1;
               cmd.result_kind = hrl_pkg::KIND_DATA;
               if (sts.emit_last) begin
                  state_in = hrl_pkg::ST_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in = hrl_pkg::ST_READ;
               end
            end
         end
         hrl_pkg::ST_HALT: begin
            state_in = hrl_pkg::ST_HALT;
         end
         default: begin
            state_in = hrl_pkg::ST_HALT;
         end
      endcase
   end

   // result valid register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a result is only loaded into a free output register
   assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> out_free)
      else $error("result loaded over a pending result");

   // completion and error reports halt the parser
   assert property (@(posedge clock) disable iff (reset)
      cmd.result_load && (cmd.result_kind != hrl_pkg::KIND_DATA) |=>
      state_ff == hrl_pkg::ST_HALT)
      else $error("parser did not halt after a report");

   // once halted and drained, no result appears
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == hrl_pkg::ST_HALT) && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result produced while halted");

   // a buffer read is always followed by its write result step
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_read |=> state_ff == hrl_pkg::ST_WRITE)
      else $error("buffer read not followed by write step");

   // requests are never taken during the write burst
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == hrl_pkg::ST_WRITE) && !out_free |=> !$past(req_fire))
      else $error("request taken during write burst");

endmodule

>>> rtl/core/hex_record_loader.sv
// ----------------------------------------------------------------------------
// hex_record_loader
// Intel HEX text parser: one character per request, data writes and reports
// as results.
// Results: a report is registered and shows on the result port in the cycle
// after the request that causes it; once a data record's ending whitespace is
// taken, its writes follow one by one, each a buffer read and then a result
// register load, with requests stalled for the burst.
// Throughput: one character per cycle while the result register is free.
// Reset (synchronous): parser idle between records, no result pending; the
// record buffer is not cleared, entries are read only after being written.
// ----------------------------------------------------------------------------
module hex_record_loader (
   input  logic          clock,
   input  logic          reset,
   hrl_req_if.sink       req_ch,
   hrl_rsp_if.source     rsp_ch
);

   hrl_pkg::cmd_type    cmd;
   hrl_pkg::status_type sts;

   // control
   hrl_ctrl ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // fields, buffer and result payload
   hrl_datapath datapath (
      .clock         (clock),
      .reset         (reset),
      .character     (req_ch.character),
      .text_end      (req_ch.text_end),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_kind      (rsp_ch.kind),
      .rsp_address   (rsp_ch.address),
      .rsp_data_byte (rsp_ch.data_byte),
      .rsp_last      (rsp_ch.last)
   );

endmodule

>>> tb/tb_hex_record_loader.sv
// ----------------------------------------------------------------------------
// tb_hex_record_loader
// Self-checking bench for the hex record loader. Intel HEX text is fed one
// character per request. Every accepted character also runs through a local
// parser model, which queues the writes and reports it should cause. Each
// result taken from the block is checked against the oldest queued one.
// Covered: whitespace kinds, digit case, empty and full-size records,
// address wrap, random data records, back pressure, and one randomly chosen
// way of ending the image. Input after the halt is also sent and must give
// no results.
// ----------------------------------------------------------------------------
module tb_hex_record_loader;
   timeunit 1ns;
   timeprecision 1ps;

   import hrl_pkg::*;

   localparam int PERIOD_NS = 8;
   localparam int RESET_CYCLES = 10;
   localparam int TIMEOUT_NS = 5_000_000;
   localparam int DRAIN_LIMIT = 50_000;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_PERCENT = 15;

   // ascii digit bases
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [7:0]  data_byte;
      logic        last;
   } load_result_type;

   typedef enum {PARSE_IDLE, PARSE_BODY, PARSE_HALTED} parse_phase_type;
   typedef enum {CASE_UPPER, CASE_LOWER, CASE_MIXED} digit_case_type;
   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_COUNT} fill_type;
   typedef enum int {
      END_RECORD,
      END_RECORD_AT_TEXT_END,
      BAD_CHECKSUM,
      STRAY_CHAR,
      NON_HEX_CHAR,
      LENGTH_TOO_LARGE,
      TOO_MANY_BYTES,
      ODD_DIGITS,
      SHORT_RECORD,
      UNSUPPORTED_TYPE,
      TEXT_END_IDLE,
      TEXT_END_AFTER_DATA,
      BARE_COLON
   } ending_type;

   logic clock;
   logic reset;

   hrl_req_if req_bus ();
   hrl_rsp_if rsp_bus ();

   hex_record_loader u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // parser model state
   parse_phase_type parse_phase;
   bit              nibble_pending;
   logic [3:0]      high_digit;
   int              rec_bytes;
   logic [7:0]      rec_sum;
   int              rec_len;
   logic [15:0]     rec_addr;
   logic [7:0]      rec_type;
   logic [7:0]      rec_buf [MAX_RECORD_BYTES];

   load_result_type writes_and_reports [$];

   int             fail_count;
   int             chars_sent;
   bit             req_idle_on;
   bit             rsp_idle_on;
   int             rsp_hold;
   digit_case_type digit_case;

   // clock
   initial begin
      clock = 1'b0;
      forever #(PERIOD_NS / 2) clock = ~clock;
   end

   // fail-safe end of run
   initial begin
      #(TIMEOUT_NS);
      $display("[hex_record_loader] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // parser model
   // ---------------------------------------------------------------------

   function automatic bit is_white(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic int hex_val(input logic [7:0] c);
      if (c >= CH_ZERO && c < CH_ZERO + 8'd10) return int'(c - CH_ZERO);
      if (c >= CH_UPPER_A && c < CH_UPPER_A + 8'd6) return int'(c - CH_UPPER_A) + 10;
      if (c >= CH_LOWER_A && c < CH_LOWER_A + 8'd6) return int'(c - CH_LOWER_A) + 10;
      return -1;
   endfunction

   // single report, then the parser stops for good
   function automatic void halt_with(input kind_type k);
      load_result_type r;
      r.kind = k;
      r.address = '0;
      r.data_byte = '0;
      r.last = 1'b1;
      writes_and_reports.push_back(r);
      parse_phase = PARSE_HALTED;
   endfunction

   // one complete byte of the record
   function automatic void take_byte(input logic [7:0] b);
      if (rec_bytes >= 1 && rec_bytes >= rec_len + FRAME_BYTES) begin
         halt_with(KIND_MALFORMED);
         return;
      end
      case (rec_bytes)
         0: begin
            if (b > MAX_RECORD_BYTES) begin
               halt_with(KIND_MALFORMED);
               return;
            end
            rec_len = b;
         end
         1: rec_addr[15:8] = b;
         2: rec_addr[7:0] = b;
         3: rec_type = b;
         default: begin
            if (rec_bytes - HEADER_BYTES < rec_len)
               rec_buf[rec_bytes - HEADER_BYTES] = b;
         end
      endcase
      rec_sum = rec_sum + b;
      rec_bytes++;
   endfunction

   // record end checks, then the write burst for a good data record
   function automatic void finish_record(input bit at_text_end);
      load_result_type r;
      if (nibble_pending || rec_bytes == 0 || rec_bytes != rec_len + FRAME_BYTES)
         halt_with(KIND_MALFORMED);
      else if (rec_sum != 8'h00)
         halt_with(KIND_CSUM);
      else if (rec_type == TYPE_END)
         halt_with(KIND_DONE);
      else if (rec_type != TYPE_DATA)
         halt_with(KIND_UNSUPPORTED);
      else if (at_text_end)
         halt_with(KIND_NO_END);
      else begin
         parse_phase = PARSE_IDLE;
         for (int k = 0; k < rec_len; k++) begin
            r.kind = KIND_DATA;
            r.address = rec_addr + 16'(k);
            r.data_byte = rec_buf[k];
            r.last = (k == rec_len - 1);
            writes_and_reports.push_back(r);
         end
      end
   endfunction

   // one accepted request
   function automatic void parse_char(input logic [7:0] c, input logic text_end);
      int v;
      if (parse_phase == PARSE_HALTED) return;
      if (parse_phase == PARSE_IDLE) begin
         if (text_end) halt_with(KIND_NO_END);
         else if (is_white(c)) return;
         else if (c != CHAR_COLON) halt_with(KIND_MALFORMED);
         else begin
            parse_phase = PARSE_BODY;
            nibble_pending = 1'b0;
            high_digit = '0;
            rec_bytes = 0;
            rec_sum = '0;
            rec_len = 0;
            rec_addr = '0;
            rec_type = '0;
         end
         return;
      end
      if (text_end) begin
         finish_record(1'b1);
         return;
      end
      if (is_white(c)) begin
         finish_record(1'b0);
         return;
      end
      v = hex_val(c);
      if (v < 0) halt_with(KIND_MALFORMED);
      else if (!nibble_pending) begin
         high_digit = v[3:0];
         nibble_pending = 1'b1;
      end else begin
         nibble_pending = 1'b0;
         take_byte({high_digit, v[3:0]});
      end
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // drive one request at the falling edge, hold until accepted
   task automatic send_item(input logic [7:0] c, input logic text_end);
      int gap;
      if (req_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         gap = $urandom_range(1, 4);
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.character = c;
      req_bus.text_end = text_end;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      parse_char(c, text_end);
      chars_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      bit upper;
      upper = (digit_case == CASE_UPPER) ||
              (digit_case == CASE_MIXED && $urandom_range(1) == 1);
      if (v < 4'd10) return CH_ZERO + 8'(v);
      return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(v) - 8'd10;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      send_item(hex_char(b[7:4]), 1'b0);
      send_item(hex_char(b[3:0]), 1'b0);
   endtask

   // any of the six whitespace characters
   task automatic send_space();
      int k;
      k = $urandom_range(0, 5);
      send_item((k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k), 1'b0);
   endtask

   // colon, header, data and checksum, with no terminator
   task automatic send_record(input logic [7:0] len_field, input logic [15:0] addr,
                              input logic [7:0] rtype, input int data_count,
                              input fill_type fill, input logic [7:0] sum_delta);
      logic [7:0] sum;
      logic [7:0] b;
      sum = len_field + addr[15:8] + addr[7:0] + rtype;
      send_item(CHAR_COLON, 1'b0);
      send_byte(len_field);
      send_byte(addr[15:8]);
      send_byte(addr[7:0]);
      send_byte(rtype);
      for (int k = 0; k < data_count; k++) begin
         case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            FILL_COUNT: b = 8'(k);
            default: b = 8'($urandom);
         endcase
         send_byte(b);
         sum = sum + b;
      end
      send_byte(8'h00 - sum + sum_delta);
   endtask

   // well-formed data record, mostly short, now and then up to full size
   task automatic send_random_data_record();
      int len;
      if ($urandom_range(9) == 0) len = $urandom_range(9, MAX_RECORD_BYTES);
      else len = $urandom_range(0, 8);
      send_record(8'(len), 16'($urandom), TYPE_DATA, len, FILL_RANDOM, 8'h00);
      send_space();
   endtask

   // ---------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------

   // ready with random gaps, or held low for a counted stretch
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_hold--;
         end else if (rsp_idle_on)
            rsp_bus.ready = ($urandom_range(99) >= IDLE_PERCENT);
         else
            rsp_bus.ready = 1'b1;
      end
   end

   // compare each accepted result with the oldest expected one
   initial begin
      load_result_type exp;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (writes_and_reports.size() == 0) begin
               $error("unexpected result: kind %0d address %h data %h last %b",
                      rsp_bus.kind, rsp_bus.address, rsp_bus.data_byte, rsp_bus.last);
               fail_count++;
            end else begin
               exp = writes_and_reports.pop_front();
               if (rsp_bus.kind !== exp.kind) begin
                  $error("kind: expected %0d, actual %0d", exp.kind, rsp_bus.kind);
                  fail_count++;
               end
               if (rsp_bus.address !== exp.address) begin
                  $error("address: expected %h, actual %h", exp.address, rsp_bus.address);
                  fail_count++;
               end
               if (rsp_bus.data_byte !== exp.data_byte) begin
                  $error("data_byte: expected %h, actual %h",
                         exp.data_byte, rsp_bus.data_byte);
                  fail_count++;
               end
               if (rsp_bus.last !== exp.last) begin
                  $error("last: expected %b, actual %b", exp.last, rsp_bus.last);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic wait_results_drained();
      while (writes_and_reports.size() != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // whitespace kinds, digit case, empty record, top address
   task automatic test_directed();
      digit_case = CASE_UPPER;
      for (int k = 0; k < 6; k++)
         send_item((k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k), 1'b0);
      send_record(8'd0, 16'h0000, TYPE_DATA, 0, FILL_ZERO, 8'h00);
      send_space();
      digit_case = CASE_LOWER;
      send_record(8'd1, 16'hFFFF, TYPE_DATA, 1, FILL_ONES, 8'h00);
      send_space();
      digit_case = CASE_UPPER;
      send_record(8'd2, 16'h0000, TYPE_DATA, 2, FILL_ZERO, 8'h00);
      send_item(CHAR_CR, 1'b0);
      send_item(CHAR_TAB + 8'd1, 1'b0);
      digit_case = CASE_MIXED;
   endtask

   // full-size record across the address wrap while results are held off
   task automatic test_backpressure();
      rsp_hold = HOLD_CYCLES;
      send_record(8'(MAX_RECORD_BYTES), 16'hFFF0, TYPE_DATA, MAX_RECORD_BYTES,
                  FILL_ONES, 8'h00);
      send_space();
      send_record(8'd8, 16'h1234, TYPE_DATA, 8, FILL_COUNT, 8'h00);
      send_space();
   endtask

   // sender waits for every result before going on
   task automatic test_drain_pause();
      send_random_data_record();
      wait_results_drained();
      send_random_data_record();
   endtask

   // random data records with random whitespace runs
   task automatic test_random_records(input int n_chars, input bit with_idle);
      int stop_at;
      req_idle_on = with_idle;
      rsp_idle_on = with_idle;
      stop_at = chars_sent + n_chars;
      while (chars_sent < stop_at) begin
         send_random_data_record();
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) send_space();
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // one way of ending the image, picked at random
   task automatic test_termination();
      ending_type ending;
      logic [7:0] c;
      int         len;
      ending = ending_type'($urandom_range(0, int'(BARE_COLON)));
      len = $urandom_range(1, 8);
      case (ending)
         END_RECORD: begin
            send_record(8'd0, 16'h0000, TYPE_END, 0, FILL_ZERO, 8'h00);
            send_space();
         end
         END_RECORD_AT_TEXT_END: begin
            send_record(8'd0, 16'h0000, TYPE_END, 0, FILL_ZERO, 8'h00);
            send_item(8'($urandom), 1'b1);
         end
         BAD_CHECKSUM: begin
            send_record(8'(len), 16'($urandom), TYPE_DATA, len, FILL_RANDOM,
                        8'($urandom_range(1, 255)));
            send_space();
         end
         STRAY_CHAR: begin
            do c = 8'($urandom); while (is_white(c) || c == CHAR_COLON);
            send_item(c, 1'b0);
         end
         NON_HEX_CHAR: begin
            if ($urandom_range(1) == 0) c = CHAR_COLON;
            else begin
               do c = 8'($urandom); while (hex_val(c) >= 0 || is_white(c));
            end
            send_item(CHAR_COLON, 1'b0);
            send_byte(8'(len));
            send_item(hex_char(4'($urandom)), 1'b0);
            send_item(c, 1'b0);
         end
         LENGTH_TOO_LARGE: begin
            send_record(8'($urandom_range(MAX_RECORD_BYTES + 1, 255)), 16'($urandom),
                        TYPE_DATA, 2, FILL_RANDOM, 8'h00);
            send_space();
         end
         TOO_MANY_BYTES: begin
            send_record(8'(len - 1), 16'($urandom), TYPE_DATA, len, FILL_RANDOM, 8'h00);
            send_space();
         end
         ODD_DIGITS: begin
            send_record(8'(len), 16'($urandom), TYPE_DATA, len, FILL_RANDOM, 8'h00);
            send_item(hex_char(4'($urandom)), 1'b0);
            send_space();
         end
         SHORT_RECORD: begin
            send_record(8'(len), 16'($urandom), TYPE_DATA, len - 1, FILL_RANDOM, 8'h00);
            send_space();
         end
         UNSUPPORTED_TYPE: begin
            send_record(8'(len), 16'($urandom), 8'($urandom_range(2, 255)), len,
                        FILL_RANDOM, 8'h00);
            send_space();
         end
         TEXT_END_IDLE: send_item(8'($urandom), 1'b1);
         TEXT_END_AFTER_DATA: begin
            send_record(8'(len), 16'($urandom), TYPE_DATA, len, FILL_RANDOM, 8'h00);
            send_item(8'($urandom), 1'b1);
         end
         default: begin
            send_item(CHAR_COLON, 1'b0);
            send_space();
         end
      endcase
   endtask

   // halted block takes any input and answers nothing
   task automatic test_after_halt();
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(CHAR_COLON, 1'b0);
      for (int k = 0; k < 20; k++)
         send_item(8'($urandom), 1'($urandom_range(1)));
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      int guard;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.character = '0;
      req_bus.text_end = 1'b0;
      fail_count = 0;
      chars_sent = 0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      rsp_hold = 0;
      digit_case = CASE_MIXED;
      parse_phase = PARSE_IDLE;
      nibble_pending = 1'b0;
      high_digit = '0;
      rec_bytes = 0;
      rec_sum = '0;
      rec_len = 0;
      rec_addr = '0;
      rec_type = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed();
      test_random_records(10, 1'b1);
      test_backpressure();
      test_drain_pause();
      test_random_records(30, 1'b0);
      test_random_records(10, 1'b1);
      test_termination();
      test_after_halt();
      req_bus.valid = 1'b0;

      // let the last results come out
      guard = 0;
      while (writes_and_reports.size() != 0 && guard < DRAIN_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (writes_and_reports.size() != 0) begin
         $error("results never arrived: %0d", writes_and_reports.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("[hex_record_loader] OK");
      else
         $display("[hex_record_loader] ERROR");
      $finish;
   end

endmodule
